// ===== rtl/bel_pkg.sv =====
// Shared types, constants and decode functions for the bang-escape decoder.
// No dependencies.
package bel_pkg;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] CharBang = 8'h21;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NONCANON = 2'd1,
    ST_INVALID  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    MODE_PLAIN = 3'b001,
    MODE_BANG1 = 3'b010,
    MODE_BANG2 = 3'b100
  } mode_e;

  // One queued command: nbang '!' beats with invalid status, then a final beat.
  typedef struct packed {
    logic [1:0] nbang;
    logic [7:0] data;
    logic       is_end;
    status_e    status;
  } bel_cmd_t;

  // {ok, value} for a byte after a single bang.
  function automatic logic [8:0] single_bang(input logic [7:0] c);
    logic [8:0] r;
    r = {1'b0, c};
    if (c >= 8'h61 && c <= 8'h7a) begin
      r = {1'b1, c - 8'd32};
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      r = {1'b1, c};
    end else begin
      unique case (c)
        8'h22:   r = {1'b1, CharBang};
        8'h30:   r = {1'b1, 8'd224};
        8'h31:   r = {1'b1, 8'd226};
        8'h32:   r = {1'b1, 8'd233};
        8'h33:   r = {1'b1, 8'd232};
        8'h34:   r = {1'b1, 8'd235};
        8'h35:   r = {1'b1, 8'd234};
        8'h36:   r = {1'b1, 8'd239};
        8'h37:   r = {1'b1, 8'd238};
        8'h38:   r = {1'b1, 8'd244};
        8'h39:   r = {1'b1, 8'd249};
        8'h3a:   r = {1'b1, 8'd251};
        8'h3d:   r = {1'b1, 8'd231};
        8'h3e:   r = {1'b1, 8'd171};
        8'h3f:   r = {1'b1, 8'd187};
        8'h3b:   r = {1'b1, 8'd230};
        8'h3c:   r = {1'b1, 8'd247};
        8'h40:   r = {1'b1, 8'h60};
        8'h5b:   r = {1'b1, 8'h7b};
        8'h5c:   r = {1'b1, 8'h7c};
        8'h5d:   r = {1'b1, 8'h7d};
        8'h5e:   r = {1'b1, 8'h7e};
        8'h5f:   r = {1'b1, 8'd127};
        default: r = {1'b0, c};
      endcase
    end
    return r;
  endfunction

  // {ok, control code} for a byte after a double bang.
  function automatic logic [8:0] double_bang(input logic [7:0] c);
    logic [8:0] r;
    r = {1'b0, c};
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = {1'b1, c - 8'h40};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r = {1'b1, c - 8'h60};
    end else begin
      unique case (c)
        8'h40:   r = {1'b1, 8'd0};
        8'h5b:   r = {1'b1, 8'd27};
        8'h5c:   r = {1'b1, 8'd28};
        8'h5d:   r = {1'b1, 8'd29};
        8'h5e:   r = {1'b1, 8'd30};
        8'h5f:   r = {1'b1, 8'd31};
        default: r = {1'b0, c};
      endcase
    end
    return r;
  endfunction

endpackage

// ===== rtl/bang_escape_to_latin1_decoder_core.sv =====
// Top level of the bang-escape to Latin-1 decoder.
// Depends on bel_pkg, bel_front, bel_queue, bel_back.
//
// Usage:
//  - Input channel: drive in_byte_i / at_end_i with push_i; a beat is taken
//    on a clock edge with push_i high and full_o low. at_end_i closes the
//    stream (in_byte_i is then ignored) and yields an end-marker result.
//  - Result channel: while empty_o is low, out_byte_o, is_end_o, status_o and
//    last_o show the oldest result; it is taken on an edge with pop_i high.
//    last_o marks the final result caused by one input beat.
//  - A '!' that opens an escape yields no result; an invalid escape yields
//    up to three results (the bangs, then the byte as written).
//  - Path: the edge that takes a beat writes the command queue; the back
//    end then loads its output reg from the queue head, so a result passes
//    through the command queue and then the back end's output reg.
//  - Throughput: one input beat per cycle while each beat yields at most one
//    result and the receiver pops; the back end emits one result per cycle
//    while the receiver pops, so the extra bang beats of an invalid escape
//    are absorbed by the 4-entry command queue.
//  - Receiver stall: the output register holds; the queue fills and full_o
//    rises once it holds four commands.
//  - Reset (rst_ni low, asynchronous): escape mode returns to plain, the
//    queue and output register are emptied.
module bang_escape_to_latin1_decoder_core import bel_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [7:0] in_byte_i,
  input  logic       at_end_i,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] out_byte_o,
  output logic       is_end_o,
  output logic [1:0] status_o,
  output logic       last_o
);

  logic     accept;
  logic     cmd_valid;
  bel_cmd_t cmd, head;
  logic     q_full, q_empty, head_pop;
  status_e  status;

  assign full_o = q_full;
  assign accept = push_i && !q_full;

  bel_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .at_end_i    (at_end_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  bel_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .wdata_i (cmd),
    .pop_i   (head_pop),
    .rdata_o (head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  bel_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!q_empty),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .empty_o      (empty_o),
    .pop_i        (pop_i),
    .out_byte_o   (out_byte_o),
    .is_end_o     (is_end_o),
    .status_o     (status),
    .last_o       (last_o)
  );

  assign status_o = status;

endmodule

// ===== rtl/bel_front.sv =====
// Front end: tracks escape mode and turns each input byte into a command.
// Depends on bel_pkg.
module bel_front import bel_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] in_byte_i,
  input  logic       at_end_i,
  output logic       cmd_valid_o,
  output bel_cmd_t   cmd_o
);

  mode_e      mode_q, mode_d;
  logic [8:0] sb, db;
  logic       has_cmd;

  assign sb = single_bang(in_byte_i);
  assign db = double_bang(in_byte_i);

  always_comb begin
    mode_d  = mode_q;
    has_cmd = 1'b1;
    cmd_o   = '{nbang: 2'd0, data: in_byte_i, is_end: 1'b0, status: ST_OK};
    if (at_end_i) begin
      mode_d       = MODE_PLAIN;
      cmd_o.data   = 8'd0;
      cmd_o.is_end = 1'b1;
      unique case (mode_q)
        MODE_BANG1: cmd_o.nbang = 2'd1;
        MODE_BANG2: cmd_o.nbang = 2'd2;
        default:    cmd_o.nbang = 2'd0;
      endcase
    end else begin
      unique case (mode_q)
        MODE_BANG1: begin
          if (in_byte_i == CharBang) begin
            mode_d  = MODE_BANG2;
            has_cmd = 1'b0;
          end else begin
            mode_d = MODE_PLAIN;
            if (sb[8]) begin
              cmd_o.data = sb[7:0];
            end else begin
              cmd_o.nbang  = 2'd1;
              cmd_o.status = ST_INVALID;
            end
          end
        end
        MODE_BANG2: begin
          mode_d = MODE_PLAIN;
          if (db[8]) begin
            cmd_o.data = db[7:0];
            if (in_byte_i == 8'h6a || in_byte_i == 8'h4a) cmd_o.status = ST_NONCANON;
          end else begin
            cmd_o.nbang  = 2'd2;
            cmd_o.status = ST_INVALID;
          end
        end
        default: begin
          if (in_byte_i == CharBang) begin
            mode_d  = MODE_BANG1;
            has_cmd = 1'b0;
          end else if (in_byte_i >= 8'h41 && in_byte_i <= 8'h5a) begin
            cmd_o.data = in_byte_i + 8'd32;
          end
        end
      endcase
    end
  end

  assign cmd_valid_o = accept_i && has_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
    end else if (accept_i) begin
      mode_q <= mode_d;
    end
  end

endmodule

// ===== rtl/bel_queue.sv =====
// Short command queue between front and back ends.
// Depends on bel_pkg.
module bel_queue import bel_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  bel_cmd_t wdata_i,
  input  logic     pop_i,
  output bel_cmd_t rdata_o,
  output logic     full_o,
  output logic     empty_o
);

  bel_cmd_t         mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/bel_back.sv =====
// Back end: expands each command into result beats into an output register.
// Depends on bel_pkg.
module bel_back import bel_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  bel_cmd_t   head_i,
  output logic       head_pop_o,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] out_byte_o,
  output logic       is_end_o,
  output status_e    status_o,
  output logic       last_o
);

  logic       out_valid_q;
  logic [1:0] idx_q;
  logic       advance, take, final_beat;

  assign advance    = !out_valid_q || pop_i;
  assign take       = advance && head_valid_i;
  assign final_beat = (idx_q == head_i.nbang);
  assign head_pop_o = take && final_beat;
  assign empty_o    = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (advance) begin
      out_valid_q <= head_valid_i;
      if (take) idx_q <= final_beat ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (final_beat) begin
        out_byte_o <= head_i.data;
        is_end_o   <= head_i.is_end;
        status_o   <= head_i.status;
        last_o     <= 1'b1;
      end else begin
        out_byte_o <= CharBang;
        is_end_o   <= 1'b0;
        status_o   <= ST_INVALID;
        last_o     <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/bel_checker.sv =====
// Port-level checks for the bang-escape decoder, bound to the top level.
// Depends on bel_pkg and bang_escape_to_latin1_decoder_core.
module bel_checker import bel_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty_o,
  input logic       pop_i,
  input logic [7:0] out_byte_o,
  input logic       is_end_o,
  input logic [1:0] status_o,
  input logic       last_o
);

  // Stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(out_byte_o) && $stable(last_o))
    else $error("result changed while stalled");

  // End marker is a final, clean zero beat.
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && is_end_o |-> last_o && status_o == ST_OK && out_byte_o == 8'd0)
    else $error("malformed end marker");

  // Only pending bangs of a failed escape come before the last beat.
  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !last_o |-> status_o == ST_INVALID && out_byte_o == CharBang && !is_end_o)
    else $error("bad non-final beat");

  // No status code beyond invalid is shown.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> status_o <= ST_INVALID)
    else $error("undefined status code");

endmodule

bind bang_escape_to_latin1_decoder_core bel_checker u_bel_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty_o    (empty_o),
  .pop_i      (pop_i),
  .out_byte_o (out_byte_o),
  .is_end_o   (is_end_o),
  .status_o   (status_o),
  .last_o     (last_o)
);
